// File: sv/uetm_pkg.sv
// Shared types and constants for the ultrasonic echo trimmed-mean block.
package uetm_pkg;

	localparam int COUNT_W = 16;
	localparam int CM_W = 11;
	localparam int TRIM_W = 12;
	localparam int SUM_W = 14;

	localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd60000;
	localparam logic [COUNT_W-1:0] CODE_TIMEOUT = 16'hFFFF;
	localparam logic [COUNT_W-1:0] CODE_CLEAR = 16'hFFFE;

	// code / 58 == (code >> 1) / 29, done as a multiply by ceil(2^20 / 29).
	localparam logic [15:0] CM_RECIP = 16'd36158;
	localparam int CM_SHIFT = 20;
	localparam int CM_PROD_W = 31;

	// trim / 3 as a multiply by ceil(2^13 / 3), exact for trim below 8192.
	localparam logic [11:0] DIV3_RECIP = 12'd2731;
	localparam int DIV3_SHIFT = 13;
	localparam int DIV3_PROD_W = 24;

	localparam logic [CM_W-1:0] DIST_MAX = 11'd1129;

	localparam int WIN_LEN = 5;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_NO_OBST = 2'd2
	} status_t;

	typedef struct packed {
		status_t         status;
		logic [CM_W-1:0] cm;
	} item_t;

endpackage

// File: sv/uetm_front.sv
// Front end: classifies each echo and converts its code to centimetres.
module uetm_front
	import uetm_pkg::*;
(
	input  logic               timed_out,
	input  logic [COUNT_W-1:0] timer_count,
	input  logic [COUNT_W-1:0] limit,
	output item_t              item
);

	logic [COUNT_W-1:0]   code;
	status_t              status;
	logic [COUNT_W-2:0]   half_code;
	logic [CM_PROD_W-1:0] prod;

	always_comb begin
		priority if (timed_out) begin
			code   = CODE_TIMEOUT;
			status = ST_TIMEOUT;
		end else if (timer_count > limit) begin
			code   = CODE_CLEAR;
			status = ST_NO_OBST;
		end else begin
			code   = {1'b0, timer_count[COUNT_W-1:1]};
			status = ST_VALID;
		end
	end

	// Dividing by 58 is halving and then dividing by 29.
	assign half_code = code[COUNT_W-1:1];
	assign prod = CM_PROD_W'(half_code) * CM_PROD_W'(CM_RECIP);

	assign item.status = status;
	assign item.cm     = prod[CM_SHIFT +: CM_W];

endmodule

// File: sv/uetm_fifo.sv
// Short queue of classified items between the front and back ends.
module uetm_fifo
	import uetm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output item_t pop_item
);

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full     = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/uetm_back.sv
// Back end: sample window, trimmed sum, divide by three and result register.
module uetm_back
	import uetm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output status_t           out_status,
	output logic [CM_W-1:0]   out_dist
);

	logic [CM_W-1:0]        window_q [WIN_LEN];
	logic [CM_W-1:0]        win_next [WIN_LEN];
	logic [SUM_W-1:0]       sum;
	logic [CM_W-1:0]        hi;
	logic [CM_W-1:0]        lo;
	logic [SUM_W-1:0]       trim_full;

	logic                   vld_s1;
	status_t                status_s1;
	logic [TRIM_W-1:0]      trim_s1;
	logic                   vld_s2;
	status_t                status_s2;
	logic [CM_W-1:0]        dist_s2;

	logic                   adv_s2;
	logic                   adv_s1;
	logic [DIV3_PROD_W-1:0] prod;

	assign adv_s2 = !vld_s2 || out_ready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign q_pop  = adv_s1 && !q_empty;

	// Window as it stands once the popped sample has been shifted in.
	always_comb begin
		for (int i = 0; i < WIN_LEN - 1; i++) begin
			win_next[i] = window_q[i + 1];
		end
		win_next[WIN_LEN-1] = q_item.cm;
	end

	always_comb begin
		sum = '0;
		hi  = win_next[0];
		lo  = win_next[0];
		for (int i = 0; i < WIN_LEN; i++) begin
			sum = sum + SUM_W'(win_next[i]);
			if (win_next[i] > hi) begin
				hi = win_next[i];
			end
			if (win_next[i] < lo) begin
				lo = win_next[i];
			end
		end
		trim_full = sum - SUM_W'(hi) - SUM_W'(lo);
	end

	assign prod = DIV3_PROD_W'(trim_s1) * DIV3_PROD_W'(DIV3_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				window_q[i] <= '0;
			end
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (q_pop) begin
				for (int i = 0; i < WIN_LEN; i++) begin
					window_q[i] <= win_next[i];
				end
			end
			if (adv_s1) begin
				vld_s1 <= !q_empty;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			status_s1 <= q_item.status;
			trim_s1   <= trim_full[TRIM_W-1:0];
		end
		if (adv_s2 && vld_s1) begin
			status_s2 <= status_s1;
			dist_s2   <= (status_s1 == ST_VALID) ? prod[DIV3_SHIFT +: CM_W] : '0;
		end
	end

	assign out_valid  = vld_s2;
	assign out_status = status_s2;
	assign out_dist   = dist_s2;

endmodule

// File: sv/ultrasonic_echo_trimmed_mean_top.sv
// Top level of the ultrasonic echo trimmed-mean block.
//
// Each input transaction carries one echo measurement: the timer count in
// s_axis_tdata and the timeout flag in s_axis_tuser. The block turns it into
// a centimetre value (count / 116, or 1129 for a timeout or for a count above
// no_obstacle_limit), shifts that value into a five-sample window that starts
// out as zeros, and returns one output transaction per input: the status in
// m_axis_tuser and, for a valid echo, the mean of the window with the largest
// and smallest samples dropped (truncating) in m_axis_tdata; error results
// carry a distance of zero. The block takes one transaction every cycle while
// the queue has room. Results pass through the queue and the two back-end
// stages (window and trimmed sum, then the divide by three into the result
// register). A four-entry queue separates the front end from the back end, so
// input keeps flowing while the output side stalls until the queue fills. The
// limit register resets to 60000; the user must write it through cfg_we and
// cfg_wdata only while no transaction is in flight, unchecked by the block.
module ultrasonic_echo_trimmed_mean_top
	import uetm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,     // no_obstacle_limit

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] timer_count
	input  logic        s_axis_tuser,  // [0] timed_out

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [10:0] distance_cm, [15:11] zero
	output logic [1:0]  m_axis_tuser   // [1:0] status
);

	logic [COUNT_W-1:0] limit_q;
	item_t              front_item;
	item_t              q_item;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;
	status_t            out_status;
	logic [CM_W-1:0]    out_dist;

	// The limit register has no read-back; a write simply replaces it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// The front end is pure logic; its result is captured by the queue.
	uetm_front u_front (
		.timed_out   (s_axis_tuser),
		.timer_count (s_axis_tdata),
		.limit       (limit_q),
		.item        (front_item)
	);

	// The input side is ready whenever the queue has a free entry.
	assign s_axis_tready = !q_full;

	uetm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_axis_tvalid),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_item  (q_item)
	);

	// The back end updates the window only when it actually pops an item.
	uetm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (out_status),
		.out_dist   (out_dist)
	);

	assign m_axis_tuser = out_status;
	assign m_axis_tdata = {(16 - CM_W)'(0), out_dist};

endmodule

// File: sv/uetm_checker.sv
// Port-level checker for the ultrasonic echo trimmed-mean block, with its bind.
module uetm_checker
	import uetm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A stalled result must hold its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// Error results never carry a distance.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_VALID) |-> m_axis_tdata == '0)
		else $error("error result with nonzero distance");

	// A trimmed mean can never exceed the largest centimetre value.
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata <= 16'(DIST_MAX))
		else $error("distance out of range");

endmodule

bind ultrasonic_echo_trimmed_mean_top uetm_checker u_uetm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// File: verif/tb.sv
// Self-checking testbench for the ultrasonic echo trimmed-mean block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import uetm_pkg::*;

	// One echo measurement as the sender holds it before it becomes a transaction.
	typedef struct packed {
		logic               timed_out;
		logic [COUNT_W-1:0] count;
	} echo_t;

	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 305;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [15:0] timer_count
	logic        s_axis_tuser = 1'b0;  // [0] timed_out
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;  // [10:0] distance_cm, [15:11] zero
	logic [1:0]  m_axis_tuser;  // [1:0] status

	ultrasonic_echo_trimmed_mean_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Measurements waiting to be sent; the head is the one on the bus while tvalid is high.
	echo_t pending_echoes[$];
	// Readings the block owes us, oldest first.
	item_t expected_readings[$];

	// Our own copy of the block state: the limit register and the sample window.
	logic [COUNT_W-1:0] echo_limit = LIMIT_RESET;
	logic [CM_W-1:0]    echo_window[WIN_LEN] = '{default: '0};

	int mismatch_count = 0;
	int idle_cycles = 0;
	bit in_taken = 1'b0;

	// Sender pacing: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	// Receiver pacing: a randomly chosen stall mode and the count left in it.
	int rdy_mode = 0;
	int rdy_left = 0;

	// A running level that the plausible echoes wander around.
	int base_count = 20000;

	initial begin
		forever #1 clk = ~clk;
	end

	// Converts one measurement to centimetres, pushes it into the window, and returns
	// the status and trimmed mean that the block should produce for it.
	function automatic item_t track_echo(input logic timed_out, input logic [COUNT_W-1:0] count);
		item_t           reading;
		logic [COUNT_W-1:0] code;
		int              sum;
		int              hi;
		int              lo;
		if (timed_out) begin
			code = CODE_TIMEOUT;
			reading.status = ST_TIMEOUT;
		end else if (count > echo_limit) begin
			code = CODE_CLEAR;
			reading.status = ST_NO_OBST;
		end else begin
			code = count >> 1;
			reading.status = ST_VALID;
		end
		for (int i = 0; i < WIN_LEN - 1; i++)
			echo_window[i] = echo_window[i + 1];
		echo_window[WIN_LEN - 1] = CM_W'(code / 16'd58);
		sum = 0;
		hi = echo_window[0];
		lo = echo_window[0];
		for (int i = 0; i < WIN_LEN; i++) begin
			sum += echo_window[i];
			if (echo_window[i] > hi)
				hi = echo_window[i];
			if (echo_window[i] < lo)
				lo = echo_window[i];
		end
		reading.cm = (reading.status == ST_VALID) ? CM_W'((sum - hi - lo) / 3) : '0;
		return reading;
	endfunction

	task automatic queue_echo(input logic timed_out, input int count);
		echo_t e;
		e.timed_out = timed_out;
		e.count = COUNT_W'(count);
		pending_echoes.push_back(e);
	endtask

	// Random measurements for one phase. Most are plausible echoes around a rarely
	// jumping level, so the window holds realistic spreads; the rest are timeouts,
	// counts hugging the limit from both sides, and raw noise over the full range.
	task automatic queue_random_echoes(input int n);
		int pick;
		int c;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 15) == 0)
				base_count = $urandom_range(0, 65535);
			if (pick < 10) begin
				queue_echo(1'b1, $urandom_range(0, 65535));
			end else if (pick < 25) begin
				c = int'(echo_limit) + $urandom_range(0, 6) - 3;
				if (c < 0)
					c = 0;
				if (c > 65535)
					c = 65535;
				queue_echo(1'b0, c);
			end else if (pick < 40) begin
				queue_echo(1'b0, $urandom_range(0, 65535));
			end else begin
				c = base_count + $urandom_range(0, 400) - 200;
				if (c < 0)
					c = 0;
				if (c > 65535)
					c = 65535;
				queue_echo(1'b0, c);
			end
		end
	endtask

	// Holds the sender back until every transaction has been accepted and answered,
	// then lets the back end run out before anything else happens.
	task automatic settle();
		while (pending_echoes.size() != 0 || expected_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// The limit is written only while the block is idle.
	task automatic write_limit(input logic [15:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sender: drives the head of the pending queue at the falling edge and holds it
	// until the transaction completes.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!(s_axis_tvalid && !in_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_echoes.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_echoes[0].count;
				s_axis_tuser <= pending_echoes[0].timed_out;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: always ready, coin flip, mostly stalled, or periodic stalls
	// that fill the internal queue and push back on the sender.
	always @(negedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode = $urandom_range(0, 3);
			rdy_left = $urandom_range(10, 80);
		end else begin
			rdy_left--;
		end
		case (rdy_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 1) == 0);
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= (rdy_left % 8 == 0);
		endcase
	end

	// Monitor: at each rising edge it checks a returned reading against the oldest
	// expectation, predicts the reading for an accepted measurement, tracks limit
	// writes, and runs the watchdog on cycles in which nothing moves.
	always @(posedge clk) begin
		item_t want;
		bit    out_taken;
		in_taken = arst_n && s_axis_tvalid && s_axis_tready;
		out_taken = arst_n && m_axis_tvalid && m_axis_tready;
		if (out_taken) begin
			if (expected_readings.size() == 0) begin
				$display("%0t: output transaction with nothing expected, status %0d distance %0d",
					$realtime, m_axis_tuser, m_axis_tdata);
				mismatch_count++;
			end else begin
				want = expected_readings.pop_front();
				if (m_axis_tuser !== want.status) begin
					$display("%0t: status mismatch, expected %0d actual %0d",
						$realtime, want.status, m_axis_tuser);
					mismatch_count++;
				end
				if (m_axis_tdata !== {5'b0, want.cm}) begin
					$display("%0t: distance mismatch, expected %0d actual %0d",
						$realtime, want.cm, m_axis_tdata);
					mismatch_count++;
				end
			end
		end
		if (arst_n && cfg_we)
			echo_limit = cfg_wdata;
		if (in_taken) begin
			expected_readings.push_back(track_echo(s_axis_tuser, s_axis_tdata));
			void'(pending_echoes.pop_front());
		end
		if (!arst_n || in_taken || out_taken || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset limit. The first readings still average in the
		// zeros left by reset.
		queue_echo(1'b0, 0);
		queue_echo(1'b0, 65535);  // no obstacle
		queue_echo(1'b1, 0);      // timeout ignores the count
		queue_echo(1'b1, 65535);
		queue_echo(1'b0, 60000);  // exactly at the limit is still valid
		queue_echo(1'b0, 60001);  // one above it is not
		queue_echo(1'b0, 115);    // truncation around the first centimetre
		queue_echo(1'b0, 116);
		queue_echo(1'b0, 117);
		queue_echo(1'b0, 232);
		// Four error samples then a short echo: the mean sits at the error value.
		queue_echo(1'b1, 1234);
		queue_echo(1'b1, 0);
		queue_echo(1'b0, 65000);
		queue_echo(1'b1, 42);
		queue_echo(1'b0, 0);
		queue_echo(1'b0, 30000);
		queue_echo(1'b0, 40000);
		queue_echo(1'b0, 50000);
		queue_echo(1'b0, 59999);
		queue_echo(1'b0, 1);
		queue_echo(1'b0, 32768);

		// Random phases, each behind a limit write: the top of the range (no count
		// can exceed it), zero, three random values, and the reset value again.
		write_limit(16'hFFFF);
		queue_echo(1'b0, 65535);
		queue_random_echoes(PHASE_ITEMS);
		write_limit(16'h0000);
		queue_echo(1'b0, 0);
		queue_echo(1'b0, 1);
		queue_random_echoes(PHASE_ITEMS);
		write_limit(16'($urandom_range(500, 5000)));
		queue_random_echoes(PHASE_ITEMS);
		write_limit(16'($urandom_range(0, 65535)));
		queue_random_echoes(PHASE_ITEMS);
		write_limit(LIMIT_RESET);
		queue_random_echoes(PHASE_ITEMS);
		write_limit(16'($urandom_range(20000, 65534)));
		queue_random_echoes(PHASE_ITEMS);

		settle();
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: ultrasonic_echo_trimmed_mean_top.f
sv/uetm_pkg.sv
sv/uetm_front.sv
sv/uetm_fifo.sv
sv/uetm_back.sv
sv/ultrasonic_echo_trimmed_mean_top.sv
sv/uetm_checker.sv
verif/tb.sv
